FILE: hdl/symbolic_mode_parser_defines.svh
// ----------------------------------------------------------------------------
// symbolic_mode_parser_defines
// Assertion macros for the mode parser.
// ----------------------------------------------------------------------------
`ifndef SYMBOLIC_MODE_PARSER_DEFINES_SVH
`define SYMBOLIC_MODE_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must hold whenever the antecedent holds
`define SMP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mode parser check failed");
// condition must hold in the cycle after the antecedent
`define SMP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mode parser check failed");
`else
`define SMP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SMP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/smp_pkg.sv
// ----------------------------------------------------------------------------
// smp_pkg
// Widths, character codes and mode bit constants for the mode parser.
// ----------------------------------------------------------------------------
package smp_pkg;

  localparam int CharW = 8;
  localparam int ModeW = 12;
  localparam int MaskW = 9;

  localparam logic [MaskW-1:0] MaskReset = 9'o022;

  // who letter masks
  localparam logic [ModeW-1:0] WhoU   = 12'o5700;
  localparam logic [ModeW-1:0] WhoG   = 12'o2070;
  localparam logic [ModeW-1:0] WhoO   = 12'o0007;
  localparam logic [ModeW-1:0] WhoAll = 12'o1777;

  // permission letter bits
  localparam logic [ModeW-1:0] PermR = 12'o0444;
  localparam logic [ModeW-1:0] PermW = 12'o0222;
  localparam logic [ModeW-1:0] PermX = 12'o0111;
  localparam logic [ModeW-1:0] PermS = 12'o6000;
  localparam logic [ModeW-1:0] PermT = 12'o1000;

  // character codes
  localparam logic [CharW-1:0] ChU     = 8'h75;
  localparam logic [CharW-1:0] ChG     = 8'h67;
  localparam logic [CharW-1:0] ChO     = 8'h6f;
  localparam logic [CharW-1:0] ChA     = 8'h61;
  localparam logic [CharW-1:0] ChR     = 8'h72;
  localparam logic [CharW-1:0] ChW     = 8'h77;
  localparam logic [CharW-1:0] ChX     = 8'h78;
  localparam logic [CharW-1:0] ChS     = 8'h73;
  localparam logic [CharW-1:0] ChT     = 8'h74;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChEq    = 8'h3d;
  localparam logic [CharW-1:0] ChComma = 8'h2c;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChSeven = 8'h37;

  // pending operator codes
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  // parse phase, one-hot
  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_OCTAL  = 6'b000010,
    PH_WHO    = 6'b000100,
    PH_OPNEW  = 6'b001000,
    PH_PERM   = 6'b010000,
    PH_COPIED = 6'b100000
  } phase_t;

endpackage

FILE: hdl/smp_ifs.sv
// ----------------------------------------------------------------------------
// smp_ifs
// Valid/ready channels for mode parser characters and results.
// ----------------------------------------------------------------------------
interface smp_char_if
  import smp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] ch;
  logic [ModeW-1:0] start_mode;
  logic             first;
  logic             last;

  modport source (output valid, ch, start_mode, first, last, input ready);
  modport sink (input valid, ch, start_mode, first, last, output ready);
endinterface

interface smp_result_if
  import smp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] new_mode;
  logic             bad_mode;

  modport source (output valid, new_mode, bad_mode, input ready);
  modport sink (input valid, new_mode, bad_mode, output ready);
endinterface

FILE: hdl/symbolic_mode_parser.sv
// ----------------------------------------------------------------------------
// symbolic_mode_parser
// Parses an octal or symbolic permission-mode string, one character per item,
// and gives the new 12-bit mode with an error flag after the last character.
//
//   channel   dir  payload                          notes
//   mode_in   in   ch, start_mode, first, last      one character per item
//   mode_out  out  new_mode, bad_mode               one item per last char
//   cfg       in   cfg_wr_en, cfg_wr_data (9 bits)  default umask
//
// One character is taken every cycle; its decode and mode update sit between
// the parse state registers and the result register. A result appears in the
// cycle after its last character. Reset (rst, synchronous) clears the parse
// state, empties the result register and sets the umask to 022 octal.
// Input stalls only while a result waits and mode_out is not ready.
// ----------------------------------------------------------------------------
`include "symbolic_mode_parser_defines.svh"

module symbolic_mode_parser
  import smp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [MaskW-1:0] cfg_wr_data,
  smp_char_if.sink         mode_in,
  smp_result_if.source     mode_out
);

  // parse state
  phase_t           phase;
  logic [ModeW-1:0] octal_value;
  logic [ModeW-1:0] work_mode;
  logic [ModeW-1:0] who_bits;
  op_t              pending_op;
  logic [ModeW-1:0] perm_bits;
  logic             error_seen;
  logic [MaskW-1:0] default_mask;

  phase_t           phase_next;
  logic [ModeW-1:0] octal_value_next;
  logic [ModeW-1:0] work_mode_next;
  logic [ModeW-1:0] who_bits_next;
  op_t              pending_op_next;
  logic [ModeW-1:0] perm_bits_next;
  logic             error_seen_next;

  // result register
  logic             out_valid;
  logic [ModeW-1:0] out_mode;
  logic             out_bad;
  logic [ModeW-1:0] res_mode;
  logic             res_bad;

  logic in_fire;
  logic out_fire;

  assign mode_in.ready = !out_valid || mode_out.ready;
  assign in_fire       = mode_in.valid && mode_in.ready;
  assign out_fire      = out_valid && mode_out.ready;

  assign mode_out.valid    = out_valid;
  assign mode_out.new_mode = out_mode;
  assign mode_out.bad_mode = out_bad;

  // apply the pending operator to a mode
  function automatic logic [ModeW-1:0] apply_op(
    input logic [ModeW-1:0] mode,
    input logic [ModeW-1:0] who,
    input logic [ModeW-1:0] perm,
    input op_t              op
  );
    logic [ModeW-1:0] b;
    logic [ModeW-1:0] r;
    b = perm & who;
    case (op)
      OP_ADD:  r = mode | b;
      OP_SUB:  r = mode & ~b;
      OP_SET:  r = (mode & ~who) | b;
      default: r = mode;
    endcase
    return r;
  endfunction

  // character decode and state update
  always_comb begin
    phase_t           sym_phase;
    op_t              op;
    logic [ModeW-1:0] who_lt;
    logic [ModeW-1:0] perm_lt;
    logic [2:0]       three;
    logic             digit;
    logic             copy_ch;

    // start of string
    if (mode_in.first) begin
      phase_next       = PH_START;
      octal_value_next = '0;
      work_mode_next   = mode_in.start_mode;
      who_bits_next    = '0;
      pending_op_next  = OP_NONE;
      perm_bits_next   = '0;
      error_seen_next  = 1'b0;
    end else begin
      phase_next       = phase;
      octal_value_next = octal_value;
      work_mode_next   = work_mode;
      who_bits_next    = who_bits;
      pending_op_next  = pending_op;
      perm_bits_next   = perm_bits;
      error_seen_next  = error_seen;
    end

    digit   = (mode_in.ch >= ChZero) && (mode_in.ch <= ChSeven);
    copy_ch = (mode_in.ch == ChU) || (mode_in.ch == ChG) || (mode_in.ch == ChO);

    case (mode_in.ch)
      ChPlus:  op = OP_ADD;
      ChMinus: op = OP_SUB;
      ChEq:    op = OP_SET;
      default: op = OP_NONE;
    endcase

    case (mode_in.ch)
      ChU:     who_lt = WhoU;
      ChG:     who_lt = WhoG;
      ChO:     who_lt = WhoO;
      ChA:     who_lt = WhoAll;
      default: who_lt = '0;
    endcase

    case (mode_in.ch)
      ChR:     perm_lt = PermR;
      ChW:     perm_lt = PermW;
      ChX:     perm_lt = PermX;
      ChS:     perm_lt = PermS;
      ChT:     perm_lt = PermT;
      default: perm_lt = '0;
    endcase

    case (mode_in.ch)
      ChU:     three = work_mode_next[8:6];
      ChG:     three = work_mode_next[5:3];
      default: three = work_mode_next[2:0];
    endcase

    sym_phase = (phase_next == PH_START) ? PH_WHO : phase_next;

    if (!error_seen_next) begin
      if ((phase_next == PH_START) && digit) begin
        // octal string begins
        octal_value_next = {{(ModeW-3){1'b0}}, mode_in.ch[2:0]};
        phase_next       = PH_OCTAL;
      end else if (phase_next == PH_OCTAL) begin
        if (digit) begin
          octal_value_next = {octal_value_next[ModeW-4:0], mode_in.ch[2:0]};
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (sym_phase == PH_WHO) begin
        // who letters of a clause, then the operator or comma after them
        phase_next = PH_WHO;
        if (who_lt != '0) begin
          who_bits_next = who_bits_next | who_lt;
        end else if (op != OP_NONE) begin
          if (who_bits_next == '0) begin
            who_bits_next = WhoAll & ~{{(ModeW-MaskW){1'b0}}, default_mask};
          end
          pending_op_next = op;
          perm_bits_next  = '0;
          phase_next      = PH_OPNEW;
        end else if (mode_in.ch == ChComma) begin
          who_bits_next   = '0;
          pending_op_next = OP_NONE;
          perm_bits_next  = '0;
        end else begin
          error_seen_next = 1'b1;
        end
      end else begin
        // operator, permission or copy letters, or a comma
        if (op != OP_NONE) begin
          work_mode_next = apply_op(work_mode_next, who_bits_next, perm_bits_next,
                                    pending_op_next);
          if (who_bits_next == '0) begin
            who_bits_next = WhoAll & ~{{(ModeW-MaskW){1'b0}}, default_mask};
          end
          pending_op_next = op;
          perm_bits_next  = '0;
          phase_next      = PH_OPNEW;
        end else if (mode_in.ch == ChComma) begin
          work_mode_next = apply_op(work_mode_next, who_bits_next, perm_bits_next,
                                    pending_op_next);
          who_bits_next   = '0;
          pending_op_next = OP_NONE;
          perm_bits_next  = '0;
          phase_next      = PH_WHO;
        end else if ((sym_phase == PH_OPNEW) && copy_ch) begin
          perm_bits_next = {3'b000, three, three, three};
          phase_next     = PH_COPIED;
        end else if ((sym_phase != PH_COPIED) && (perm_lt != '0)) begin
          perm_bits_next = perm_bits_next | perm_lt;
          phase_next     = PH_PERM;
        end else begin
          error_seen_next = 1'b1;
        end
      end
    end

    // result of a finished string
    if (error_seen_next) begin
      res_mode = '0;
      res_bad  = 1'b1;
    end else if ((phase_next == PH_START) || (phase_next == PH_OCTAL)) begin
      res_mode = octal_value_next;
      res_bad  = 1'b0;
    end else if (phase_next != PH_WHO) begin
      res_mode = apply_op(work_mode_next, who_bits_next, perm_bits_next,
                          pending_op_next);
      res_bad  = 1'b0;
    end else begin
      res_mode = work_mode_next;
      res_bad  = 1'b0;
    end

    // clear after the last character
    if (mode_in.last) begin
      phase_next       = PH_START;
      octal_value_next = '0;
      work_mode_next   = '0;
      who_bits_next    = '0;
      pending_op_next  = OP_NONE;
      perm_bits_next   = '0;
      error_seen_next  = 1'b0;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      octal_value <= '0;
      work_mode   <= '0;
      who_bits    <= '0;
      pending_op  <= OP_NONE;
      perm_bits   <= '0;
      error_seen  <= 1'b0;
    end else if (in_fire) begin
      phase       <= phase_next;
      octal_value <= octal_value_next;
      work_mode   <= work_mode_next;
      who_bits    <= who_bits_next;
      pending_op  <= pending_op_next;
      perm_bits   <= perm_bits_next;
      error_seen  <= error_seen_next;
    end
  end

  // umask register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_mask <= MaskReset;
    end else if (cfg_wr_en) begin
      default_mask <= cfg_wr_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && mode_in.last) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && mode_in.last) begin
      out_mode <= res_mode;
      out_bad  <= res_bad;
    end
  end

  // checks
  `SMP_ASSERT_IMPLY(a_phase_onehot, clk, rst, 1'b1, $onehot(phase))
  `SMP_ASSERT_IMPLY(a_bad_zero_mode, clk, rst, out_valid && out_bad, out_mode == '0)
  `SMP_ASSERT_NEXT(a_last_gives_result, clk, rst, in_fire && mode_in.last, out_valid)
  `SMP_ASSERT_NEXT(a_last_clears, clk, rst, in_fire && mode_in.last,
    (phase == PH_START) && !error_seen && (work_mode == '0))

endmodule
